### design/lmpc_pkg.sv
// ----------------------------------------------------------------------------
// lmpc_pkg
// Shared types and constants of the lift motor position controller.
// ----------------------------------------------------------------------------
package lmpc_pkg;

  // Request modes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_PULSE = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;
  localparam logic [1:0] MODE_LOAD  = 2'd3;

  // Busy levels
  localparam logic [1:0] BUSY_IDLE  = 2'd0;
  localparam logic [1:0] BUSY_CREEP = 2'd1;
  localparam logic [1:0] BUSY_SLOW  = 2'd2;
  localparam logic [1:0] BUSY_FULL  = 2'd3;

  // Configuration register indexes
  localparam logic [0:0] REG_SCALE      = 1'd0;
  localparam logic [0:0] REG_SENSOR_POS = 1'd1;

  localparam logic [15:0]        SCALE_RESET      = 16'd7700;
  localparam logic signed [15:0] SENSOR_POS_RESET = 16'sd0;

  // Division of a 31-bit magnitude by 10000: (n * SCALE_RECIP) >> SCALE_SHIFT.
  localparam logic [31:0] SCALE_RECIP = 32'd3518437209;
  localparam int          SCALE_SHIFT = 45;

  // Division of speed * 255 (at most 25500) by 100.
  localparam logic [14:0] PCT_RECIP = 15'd20972;
  localparam int          PCT_SHIFT = 21;

  localparam logic [7:0] PCT_MIN = 8'd2;
  localparam logic [7:0] PCT_MAX = 8'd100;

  localparam logic signed [15:0] END_MAX = 16'sd32767;
  localparam logic signed [15:0] END_MIN = -16'sd32768;

  localparam logic signed [16:0] SLOW_ZONE  = 17'sd154;
  localparam logic signed [16:0] CREEP_ZONE = 17'sd77;
  localparam logic [7:0]         SLOW_CAP   = 8'd50;
  localparam logic [7:0]         CREEP_CAP  = 8'd25;
  localparam logic [7:0]         DUTY_END   = 8'd1;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] target_position;
    logic [7:0]         speed_percent;
    logic               sensor_level;
    logic signed [15:0] load_value;
  } item_t;

  // Request after the scale multiply and the duty conversion
  typedef struct packed {
    logic [1:0]         mode;
    logic               start_en;
    logic [7:0]         duty;
    logic               sensor_level;
    logic signed [15:0] load_value;
    logic               neg;
    logic [30:0]        mag;
  } prod_t;

  // Request with the end count resolved, as the state stage needs it
  typedef struct packed {
    logic [1:0]         mode;
    logic               start_en;
    logic [7:0]         duty;
    logic               sensor_level;
    logic signed [15:0] load_value;
    logic signed [15:0] end_value;
  } calc_t;

endpackage

### design/lmpc_cmd_if.sv
// ----------------------------------------------------------------------------
// lmpc_cmd_if
// Command channel: one request per valid/ready handshake.
// ----------------------------------------------------------------------------
interface lmpc_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [15:0] target_position;
  logic [7:0]         speed_percent;
  logic               sensor_level;
  logic signed [15:0] load_value;

  modport source (
    output valid, mode, target_position, speed_percent, sensor_level, load_value,
    input  ready
  );
  modport sink (
    input  valid, mode, target_position, speed_percent, sensor_level, load_value,
    output ready
  );
endinterface

### design/lmpc_status_if.sv
// ----------------------------------------------------------------------------
// lmpc_status_if
// Status channel: one motor status report per request.
// ----------------------------------------------------------------------------
interface lmpc_status_if;
  logic               valid;
  logic               ready;
  logic [7:0]         pwm_duty;
  logic [1:0]         busy_level;
  logic               direction_up;
  logic               clock_enabled;
  logic               high_current;
  logic signed [15:0] position_count;

  modport source (
    output valid, pwm_duty, busy_level, direction_up, clock_enabled, high_current,
           position_count,
    input  ready
  );
  modport sink (
    input  valid, pwm_duty, busy_level, direction_up, clock_enabled, high_current,
           position_count,
    output ready
  );
endinterface

### design/lmpc_end_calc.sv
// ----------------------------------------------------------------------------
// lmpc_end_calc
// Three-stage front end: input register, scale multiply with duty
// conversion, and division by 10000 with saturation to 16 bits.
// ----------------------------------------------------------------------------
module lmpc_end_calc (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  lmpc_pkg::item_t       item,
  input  logic [15:0]           scale,
  output logic                  calc_valid,
  input  logic                  calc_ready,
  output lmpc_pkg::calc_t       calc
);

  logic            s1_valid, s2_valid, s3_valid;
  logic            s1_en, s2_en, s3_en;
  lmpc_pkg::item_t s1;
  lmpc_pkg::prod_t s2, s2_next;
  lmpc_pkg::calc_t s3, s3_next;

  logic signed [32:0] prod;
  logic signed [32:0] mag_wide;
  logic [6:0]         spd;
  logic [14:0]        spd_x255;
  logic [29:0]        duty_wide;
  logic [62:0]        quot_wide;
  logic [17:0]        quot;
  logic signed [18:0] quot_signed;

  // A stage loads when it is empty or its contents move on.
  assign s3_en      = !s3_valid || calc_ready;
  assign s2_en      = !s2_valid || s3_en;
  assign s1_en      = !s1_valid || s2_en;
  assign item_ready = s1_en;

  // Stage 2: target times scale, and speed percent to duty.
  always_comb begin
    prod     = 33'(s1.target_position) * $signed({17'd0, scale});
    mag_wide = (prod < 0) ? -prod : prod;
    if (s1.speed_percent < lmpc_pkg::PCT_MIN) begin
      spd = 7'(lmpc_pkg::PCT_MIN);
    end else if (s1.speed_percent > lmpc_pkg::PCT_MAX) begin
      spd = 7'(lmpc_pkg::PCT_MAX);
    end else begin
      spd = s1.speed_percent[6:0];
    end
    spd_x255  = {spd, 8'd0} - 15'(spd);
    duty_wide = 30'(spd_x255) * 30'(lmpc_pkg::PCT_RECIP);

    s2_next.mode         = s1.mode;
    s2_next.start_en     = (s1.speed_percent != 8'd0);
    s2_next.duty         = duty_wide[lmpc_pkg::PCT_SHIFT +: 8];
    s2_next.sensor_level = s1.sensor_level;
    s2_next.load_value   = s1.load_value;
    s2_next.neg          = (prod < 0);
    s2_next.mag          = mag_wide[30:0];
  end

  // Stage 3: truncating division by 10000, then saturation.
  always_comb begin
    quot_wide   = 63'(s2.mag) * 63'(lmpc_pkg::SCALE_RECIP);
    quot        = quot_wide[lmpc_pkg::SCALE_SHIFT +: 18];
    quot_signed = s2.neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

    s3_next.mode         = s2.mode;
    s3_next.start_en     = s2.start_en;
    s3_next.duty         = s2.duty;
    s3_next.sensor_level = s2.sensor_level;
    s3_next.load_value   = s2.load_value;
    if (quot_signed > 19'(lmpc_pkg::END_MAX)) begin
      s3_next.end_value = lmpc_pkg::END_MAX;
    end else if (quot_signed < 19'(lmpc_pkg::END_MIN)) begin
      s3_next.end_value = lmpc_pkg::END_MIN;
    end else begin
      s3_next.end_value = quot_signed[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_en) s1_valid <= item_valid;
      if (s2_en) s2_valid <= s1_valid;
      if (s3_en) s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && item_valid) s1 <= item;
    if (s2_en && s1_valid)   s2 <= s2_next;
    if (s3_en && s2_valid)   s3 <= s3_next;
  end

  assign calc_valid = s3_valid;
  assign calc       = s3;

endmodule

### design/lmpc_core.sv
// ----------------------------------------------------------------------------
// lmpc_core
// Motor state: start, tacho pulse, stop and load, with the status register.
// ----------------------------------------------------------------------------
module lmpc_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic signed [15:0]    sensor_pos,
  input  logic                  calc_valid,
  output logic                  calc_ready,
  input  lmpc_pkg::calc_t       calc,
  lmpc_status_if.source         status
);

  logic signed [15:0] position, position_next;
  logic signed [15:0] end_position, end_position_next;
  logic [7:0]         duty_level, duty_level_next;
  logic [7:0]         pwm_output, pwm_output_next;
  logic [1:0]         busy, busy_next;
  logic               moving_up, moving_up_next;
  logic               last_sensor, last_sensor_next;
  logic               clock_on, clock_on_next;
  logic               drive_high, drive_high_next;

  logic               out_valid;
  logic               take;
  logic signed [15:0] pos_base;
  logic signed [15:0] step_pos;
  logic signed [16:0] remaining;

  assign calc_ready = !out_valid || status.ready;
  assign take       = calc_valid && calc_ready;

  // Pulse: resync on a sensor change, step, and measure the distance left.
  always_comb begin
    pos_base  = (calc.sensor_level != last_sensor) ? sensor_pos : position;
    step_pos  = moving_up ? (pos_base + 16'sd1) : (pos_base - 16'sd1);
    remaining = moving_up ? (17'(end_position) - 17'(step_pos))
                          : (17'(step_pos) - 17'(end_position));
  end

  always_comb begin
    position_next     = position;
    end_position_next = end_position;
    duty_level_next   = duty_level;
    pwm_output_next   = pwm_output;
    busy_next         = busy;
    moving_up_next    = moving_up;
    last_sensor_next  = last_sensor;
    clock_on_next     = clock_on;
    drive_high_next   = drive_high;

    unique case (calc.mode)
      lmpc_pkg::MODE_START: begin
        if (calc.start_en) begin
          end_position_next = calc.end_value;
          last_sensor_next  = calc.sensor_level;
          duty_level_next   = calc.duty;
          if (position != calc.end_value) begin
            moving_up_next  = (position < calc.end_value);
            drive_high_next = 1'b1;
            pwm_output_next = calc.duty;
            busy_next       = lmpc_pkg::BUSY_FULL;
            clock_on_next   = 1'b1;
          end
        end
      end
      lmpc_pkg::MODE_PULSE: begin
        if (clock_on) begin
          last_sensor_next = calc.sensor_level;
          position_next    = step_pos;
          if (remaining <= lmpc_pkg::SLOW_ZONE) begin
            if (remaining <= lmpc_pkg::CREEP_ZONE) begin
              busy_next = lmpc_pkg::BUSY_CREEP;
              if (duty_level > lmpc_pkg::CREEP_CAP) duty_level_next = lmpc_pkg::CREEP_CAP;
            end else begin
              busy_next = lmpc_pkg::BUSY_SLOW;
              if (duty_level > lmpc_pkg::SLOW_CAP) duty_level_next = lmpc_pkg::SLOW_CAP;
            end
            pwm_output_next = duty_level_next;
          end
          // End reached or passed: park the motor at the end duty of 1.
          if (remaining <= 17'sd0) begin
            busy_next       = lmpc_pkg::BUSY_IDLE;
            clock_on_next   = 1'b0;
            drive_high_next = 1'b0;
            duty_level_next = lmpc_pkg::DUTY_END;
            pwm_output_next = lmpc_pkg::DUTY_END;
          end
        end
      end
      lmpc_pkg::MODE_STOP: begin
        pwm_output_next = 8'd0;
        busy_next       = lmpc_pkg::BUSY_IDLE;
        clock_on_next   = 1'b0;
        drive_high_next = 1'b0;
      end
      lmpc_pkg::MODE_LOAD: begin
        position_next = calc.load_value;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= 16'sd0;
      end_position <= 16'sd0;
      duty_level   <= 8'd0;
      pwm_output   <= 8'd0;
      busy         <= lmpc_pkg::BUSY_IDLE;
      moving_up    <= 1'b1;
      last_sensor  <= 1'b0;
      clock_on     <= 1'b0;
      drive_high   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (take) begin
        position     <= position_next;
        end_position <= end_position_next;
        duty_level   <= duty_level_next;
        pwm_output   <= pwm_output_next;
        busy         <= busy_next;
        moving_up    <= moving_up_next;
        last_sensor  <= last_sensor_next;
        clock_on     <= clock_on_next;
        drive_high   <= drive_high_next;
        out_valid    <= 1'b1;
      end else if (status.ready) begin
        out_valid    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status.pwm_duty       <= pwm_output_next;
      status.busy_level     <= busy_next;
      status.direction_up   <= moving_up_next;
      status.clock_enabled  <= clock_on_next;
      status.high_current   <= drive_high_next;
      status.position_count <= position_next;
    end
  end

  assign status.valid = out_valid;

  // The motor clock, high current and a nonzero busy level always go together.
  a_clock_busy: assert property (@(posedge clk) disable iff (rst)
    (clock_on == (busy != lmpc_pkg::BUSY_IDLE)) && (drive_high == clock_on))
    else $error("clock enable, drive current and busy level disagree");

  // A pending status report always mirrors the current state.
  a_status_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status.position_count == position) && (status.clock_enabled == clock_on)
                  && (status.pwm_duty == pwm_output) && (status.busy_level == busy))
    else $error("status report does not match motor state");

  // A stop request leaves the motor halted with zero duty.
  a_stop_halts: assert property (@(posedge clk) disable iff (rst)
    (take && calc.mode == lmpc_pkg::MODE_STOP) |=> (!clock_on && pwm_output == 8'd0))
    else $error("stop request did not halt the motor");

endmodule

### design/lift_motor_position_controller_top.sv
// ----------------------------------------------------------------------------
// lift_motor_position_controller_top
// Lift motor position controller: turns start, tacho pulse, stop and load
// requests into PWM duty, direction and drive status.
//
//   channel  | kind         | content
//   ---------+--------------+-------------------------------------------------
//   cmd      | valid/ready  | mode, target_position, speed_percent,
//            |              | sensor_level, load_value
//   status   | valid/ready  | pwm_duty, busy_level, direction_up,
//            |              | clock_enabled, high_current, position_count
//   cfg      | write only   | cfg_write, cfg_index, cfg_data
//
// One request per cycle while the status output does not stall; its status is
// registered after the input register, scale multiply, divide by 10000 and state update.
// The motor state is updated once per request in the last stage only.
// A stalled status output holds every full stage with no empty stage after it; empty stages still fill.
// Reset is synchronous and restores the register defaults and the idle state.
// ----------------------------------------------------------------------------
module lift_motor_position_controller_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  lmpc_cmd_if.sink           cmd,
  lmpc_status_if.source      status
);

  logic [15:0]        scale;
  logic signed [15:0] sensor_pos;
  lmpc_pkg::item_t    item;
  lmpc_pkg::calc_t    calc;
  logic               calc_valid;
  logic               calc_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale      <= lmpc_pkg::SCALE_RESET;
      sensor_pos <= lmpc_pkg::SENSOR_POS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lmpc_pkg::REG_SCALE:      scale      <= cfg_data;
        lmpc_pkg::REG_SENSOR_POS: sensor_pos <= $signed(cfg_data);
      endcase
    end
  end

  always_comb begin
    item.mode            = cmd.mode;
    item.target_position = cmd.target_position;
    item.speed_percent   = cmd.speed_percent;
    item.sensor_level    = cmd.sensor_level;
    item.load_value      = cmd.load_value;
  end

  lmpc_end_calc u_end_calc (
    .clk        (clk),
    .rst        (rst),
    .item_valid (cmd.valid),
    .item_ready (cmd.ready),
    .item       (item),
    .scale      (scale),
    .calc_valid (calc_valid),
    .calc_ready (calc_ready),
    .calc       (calc)
  );

  lmpc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .sensor_pos (sensor_pos),
    .calc_valid (calc_valid),
    .calc_ready (calc_ready),
    .calc       (calc),
    .status     (status)
  );

endmodule

### tb/lift_motor_position_controller_top_tb.sv
// ----------------------------------------------------------------------------
// lift_motor_position_controller_top_tb
// Drives start, tacho pulse, stop and load requests into the lift motor
// controller under several scale and home count settings, predicts every
// status report, and compares each report field by field in request order.
// ----------------------------------------------------------------------------
module lift_motor_position_controller_top_tb;

  localparam int DUTY_FULL    = 255;
  localparam int SCALE_DIV    = 10000;
  localparam int RANDOM_ITEMS = 1100;
  localparam int PHASES       = 5;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [7:0]         pwm_duty;
    logic [1:0]         busy_level;
    logic               direction_up;
    logic               clock_enabled;
    logic               high_current;
    logic signed [15:0] position_count;
  } status_t;

  class lift_status_board;
    logic [15:0]        scale;
    logic signed [15:0] home_count;
    logic signed [15:0] position;
    logic signed [15:0] end_count;
    logic [7:0]         duty;
    logic [7:0]         pwm;
    logic [1:0]         busy;
    logic               up;
    logic               last_sensor;
    logic               clk_on;
    logic               hi_cur;
    status_t            status_due_q[$];
    int                 errors;
    int                 reports;
    int                 landings;

    function new();
      scale       = lmpc_pkg::SCALE_RESET;
      home_count  = lmpc_pkg::SENSOR_POS_RESET;
      position    = '0;
      end_count   = '0;
      duty        = '0;
      pwm         = '0;
      busy        = lmpc_pkg::BUSY_IDLE;
      up          = 1'b1;
      last_sensor = 1'b0;
      clk_on      = 1'b0;
      hi_cur      = 1'b0;
      errors      = 0;
      reports     = 0;
      landings    = 0;
    endfunction

    function void write_register(logic [0:0] idx, logic [15:0] val);
      if (idx == lmpc_pkg::REG_SCALE) begin
        scale = val;
      end else begin
        home_count = val;
      end
    endfunction

    function void start_move(logic signed [15:0] tgt, logic [7:0] spd, logic sens);
      longint span;
      int     pct;
      if (spd == 0) return;
      // Signed division truncates toward zero, then the count saturates.
      span = longint'(tgt) * longint'(scale) / SCALE_DIV;
      if (span > 32767) span = 32767;
      if (span < -32768) span = -32768;
      end_count   = span[15:0];
      last_sensor = sens;
      pct = int'(spd);
      if (pct < int'(lmpc_pkg::PCT_MIN)) pct = int'(lmpc_pkg::PCT_MIN);
      if (pct > int'(lmpc_pkg::PCT_MAX)) pct = int'(lmpc_pkg::PCT_MAX);
      duty = 8'(pct * DUTY_FULL / int'(lmpc_pkg::PCT_MAX));
      // Already there: the motor state is left as it was.
      if (position == end_count) return;
      up     = (position < end_count);
      hi_cur = 1'b1;
      pwm    = duty;
      busy   = lmpc_pkg::BUSY_FULL;
      clk_on = 1'b1;
    endfunction

    function void step_tacho(logic sens);
      int remaining;
      if (!clk_on) return;
      if (sens != last_sensor) position = home_count;
      last_sensor = sens;
      if (up) begin
        position  = position + 16'sd1;
        remaining = int'(end_count) - int'(position);
      end else begin
        position  = position - 16'sd1;
        remaining = int'(position) - int'(end_count);
      end
      if (remaining <= int'(lmpc_pkg::SLOW_ZONE)) begin
        if (remaining <= int'(lmpc_pkg::CREEP_ZONE)) begin
          busy = lmpc_pkg::BUSY_CREEP;
          if (duty > lmpc_pkg::CREEP_CAP) duty = lmpc_pkg::CREEP_CAP;
        end else begin
          busy = lmpc_pkg::BUSY_SLOW;
          if (duty > lmpc_pkg::SLOW_CAP) duty = lmpc_pkg::SLOW_CAP;
        end
        pwm = duty;
      end
      if (remaining <= 0) begin
        busy   = lmpc_pkg::BUSY_IDLE;
        clk_on = 1'b0;
        hi_cur = 1'b0;
        duty   = lmpc_pkg::DUTY_END;
        pwm    = lmpc_pkg::DUTY_END;
        landings++;
      end
    endfunction

    function void note_request(lmpc_pkg::item_t req);
      status_t due;
      case (req.mode)
        lmpc_pkg::MODE_START:
          start_move(req.target_position, req.speed_percent, req.sensor_level);
        lmpc_pkg::MODE_PULSE: step_tacho(req.sensor_level);
        lmpc_pkg::MODE_STOP: begin
          pwm    = '0;
          busy   = lmpc_pkg::BUSY_IDLE;
          clk_on = 1'b0;
          hi_cur = 1'b0;
        end
        lmpc_pkg::MODE_LOAD: position = req.load_value;
      endcase
      due.pwm_duty       = pwm;
      due.busy_level     = busy;
      due.direction_up   = up;
      due.clock_enabled  = clk_on;
      due.high_current   = hi_cur;
      due.position_count = position;
      status_due_q.push_back(due);
    endfunction

    function void compare(string field, logic signed [31:0] want, logic signed [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_status(status_t got);
      status_t due;
      reports++;
      if (status_due_q.size() == 0) begin
        $error("status report arrived with no request outstanding");
        errors++;
        return;
      end
      due = status_due_q.pop_front();
      compare("pwm_duty", due.pwm_duty, got.pwm_duty);
      compare("busy_level", due.busy_level, got.busy_level);
      compare("direction_up", due.direction_up, got.direction_up);
      compare("clock_enabled", due.clock_enabled, got.clock_enabled);
      compare("high_current", due.high_current, got.high_current);
      compare("position_count", int'(due.position_count), int'(got.position_count));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_data;

  lmpc_cmd_if    cmd_ch();
  lmpc_status_if status_ch();

  lift_motor_position_controller_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch),
    .status    (status_ch)
  );

  lift_status_board sb;
  int   gap_odds;
  int   stall_odds;
  int   stall_left;
  int   cycles;
  int   sent;
  int   phase_end;
  logic home_level;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[lift_motor_position_controller_top] ERROR");
      $finish;
    end
  end

  // Back-pressure on the status channel comes in bursts of random length.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      status_ch.ready <= 1'b0;
    end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      stall_left = $urandom_range(1, 10) - 1;
      status_ch.ready <= 1'b0;
    end else begin
      status_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    status_t got;
    if (!rst && status_ch.valid === 1'b1 && status_ch.ready === 1'b1) begin
      got.pwm_duty       = status_ch.pwm_duty;
      got.busy_level     = status_ch.busy_level;
      got.direction_up   = status_ch.direction_up;
      got.clock_enabled  = status_ch.clock_enabled;
      got.high_current   = status_ch.high_current;
      got.position_count = status_ch.position_count;
      sb.check_status(got);
    end
  end

  task automatic send(logic [1:0] mode, logic signed [15:0] tgt, logic [7:0] spd,
                      logic sens, logic signed [15:0] ld);
    lmpc_pkg::item_t req;
    req.mode            = mode;
    req.target_position = tgt;
    req.speed_percent   = spd;
    req.sensor_level    = sens;
    req.load_value      = ld;
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    cmd_ch.valid           <= 1'b1;
    cmd_ch.mode            <= mode;
    cmd_ch.target_position <= tgt;
    cmd_ch.speed_percent   <= spd;
    cmd_ch.sensor_level    <= sens;
    cmd_ch.load_value      <= ld;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    sb.note_request(req);
    sent++;
  endtask

  task automatic start(int tgt, int spd);
    send(lmpc_pkg::MODE_START, 16'(tgt), 8'(spd), home_level, 16'($urandom));
  endtask

  task automatic pulse();
    send(lmpc_pkg::MODE_PULSE, 16'($urandom), 8'($urandom), home_level, 16'($urandom));
  endtask

  task automatic stop();
    send(lmpc_pkg::MODE_STOP, 16'($urandom), 8'($urandom), 1'($urandom), 16'($urandom));
  endtask

  task automatic load(logic signed [15:0] val);
    send(lmpc_pkg::MODE_LOAD, 16'($urandom), 8'($urandom), 1'($urandom), val);
  endtask

  // Registers change only with the pipeline drained.
  task automatic set_config(logic [15:0] scale, logic [15:0] home);
    cmd_ch.valid <= 1'b0;
    while (sb.status_due_q.size() != 0) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= lmpc_pkg::REG_SCALE;
    cfg_data  <= scale;
    @(posedge clk);
    sb.write_register(lmpc_pkg::REG_SCALE, scale);
    cfg_index <= lmpc_pkg::REG_SENSOR_POS;
    cfg_data  <= home;
    @(posedge clk);
    sb.write_register(lmpc_pkg::REG_SENSOR_POS, home);
    cfg_write <= 1'b0;
  endtask

  // One move: a start aimed a random distance away, then tacho pulses until
  // the end count (or 400 requests), with the odd sensor edge, stop, load or restart mixed in.
  task automatic run_move();
    int want;
    int tgt;
    int n;
    int pick;
    if ($urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 1) == 0) begin
        load(16'(int'($urandom_range(0, 400)) - 200));
      end else begin
        load(16'($urandom));
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      send(2'($urandom), 16'($urandom), 8'($urandom), 1'($urandom), 16'($urandom));
    end
    pick = $urandom_range(0, 3);
    want = int'(sb.position);
    if (pick < 2) begin
      want = want + int'($urandom_range(0, 40)) - 20;
    end else if (pick == 2) begin
      want = want + int'($urandom_range(0, 200)) - 100;
    end else begin
      want = want + int'($urandom_range(0, 600)) - 300;
    end
    tgt = want * SCALE_DIV / int'(sb.scale);
    if (tgt > 32767) tgt = 32767;
    if (tgt < -32768) tgt = -32768;
    start(tgt, ($urandom_range(0, 19) == 0) ? 0 : int'($urandom_range(1, 255)));
    n = 0;
    while (sb.clk_on && n < 400 && sent < phase_end) begin
      if ($urandom_range(0, 49) == 0) home_level = !home_level;
      case ($urandom_range(0, 99))
        0: stop();
        1: load(16'(int'(sb.position) + int'($urandom_range(0, 20)) - 10));
        2: start(int'(16'($urandom)), int'($urandom_range(1, 255)));
        default: pulse();
      endcase
      n++;
    end
    if (sb.clk_on) stop();
    if ($urandom_range(0, 3) == 0) begin
      if ($urandom_range(0, 1) == 0) home_level = !home_level;
      pulse();
    end
  endtask

  initial begin
    logic [15:0] scales [PHASES];
    logic [15:0] homes  [PHASES];
    int          gaps   [PHASES];
    int          stalls [PHASES];

    sb                     = new();
    rst                    = 1'b1;
    cfg_write              = 1'b0;
    cfg_index              = lmpc_pkg::REG_SCALE;
    cfg_data               = '0;
    cmd_ch.valid           = 1'b0;
    cmd_ch.mode            = lmpc_pkg::MODE_STOP;
    cmd_ch.target_position = '0;
    cmd_ch.speed_percent   = '0;
    cmd_ch.sensor_level    = 1'b0;
    cmd_ch.load_value      = '0;
    status_ch.ready        = 1'b0;
    home_level             = 1'b0;
    gap_odds               = 3;
    stall_odds             = 3;
    phase_end              = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed requests under the reset register values.
    start(1000, 0);                // zero speed is ignored
    start(1, 50);                  // end count equals position, motor stays off
    home_level = 1'b1;
    pulse();                       // clock off, sensor edge not sampled
    start(-3, 1);                  // truncates to -2, speed clamps up, moves down
    pulse();
    pulse();                       // end reached
    start(130, 255);               // speed clamps to 100 percent, up
    pulse();
    stop();
    pulse();
    start(-200, 80);
    pulse();
    start(300, 100);               // restart while moving
    pulse();
    stop();

    set_config(16'hFFFF, 16'h7FFF);
    start(32767, 100);             // end count saturates high
    home_level = 1'b0;
    pulse();                       // sensor edge reloads 32767, position wraps
    start(-32768, 100);            // already at the saturated low end count
    pulse();
    stop();
    load(16'sh7FFF);
    load(16'sh8000);

    set_config(16'd1, 16'h8000);
    start(32767, 2);
    home_level = 1'b1;
    pulse();
    stop();

    scales[0] = lmpc_pkg::SCALE_RESET;  homes[0] = lmpc_pkg::SENSOR_POS_RESET;
    scales[1] = 16'd1;                  homes[1] = 16'h8000;
    scales[2] = 16'hFFFF;               homes[2] = 16'h7FFF;
    scales[3] = 16'($urandom_range(1, 65535));
    homes[3]  = 16'($urandom);
    scales[4] = 16'd10000;
    homes[4]  = 16'(int'($urandom_range(0, 200)) - 100);
    gaps[0] = 4; stalls[0] = 4;
    gaps[1] = 0; stalls[1] = 3;
    gaps[2] = 3; stalls[2] = 0;
    gaps[3] = 6; stalls[3] = 6;
    gaps[4] = 0; stalls[4] = 0;    // the closing stretch runs without idling

    for (int ph = 0; ph < PHASES; ph++) begin
      set_config(scales[ph], homes[ph]);
      gap_odds   = gaps[ph];
      stall_odds = stalls[ph];
      phase_end  = sent + RANDOM_ITEMS / PHASES;
      while (sent < phase_end) run_move();
    end

    cmd_ch.valid <= 1'b0;
    while (sb.status_due_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d requests and checked %0d status reports.", sent, sb.reports);
    $display("%0d moves reached their end count across %0d register settings.",
             sb.landings, PHASES + 2);
    if (sb.errors == 0) begin
      $display("[lift_motor_position_controller_top] OK");
    end else begin
      $display("[lift_motor_position_controller_top] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
design/lmpc_pkg.sv
design/lmpc_cmd_if.sv
design/lmpc_status_if.sv
design/lmpc_end_calc.sv
design/lmpc_core.sv
design/lift_motor_position_controller_top.sv
tb/lift_motor_position_controller_top_tb.sv
